@@ hw/rtl/rotation_matrix_to_euler_defines.svh @@
// Assertion macros shared by the checker
`ifndef ROTATION_MATRIX_TO_EULER_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_DEFINES_SVH

// same-cycle implication, masked during reset
`define RME_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rme assertion failed");

// next-cycle implication, masked during reset
`define RME_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rme assertion failed");

// implication that also holds through reset
`define RME_ASSERT_RAW(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("rme assertion failed");

`endif

@@ hw/rtl/rme_pkg.sv @@
package rme_pkg;

   localparam int RME_CORDIC_STAGES = 16;
   localparam int RME_TABLE_LEN     = 24;
   localparam int RME_SQRT_STEPS    = 16;
   localparam int RME_QUEUE_DEPTH   = 4;
   localparam int RME_ZW            = 26;
   localparam int RME_VW            = 34;

   localparam logic signed [RME_ZW-1:0] RME_HALF_TURN = 26'sd5898240;
   localparam logic signed [15:0]       RME_ANGLE_MAX = 16'sd23040;
   localparam logic signed [15:0]       RME_PITCH_MAX = 16'sd11520;

   // matrix entries as taken from the input beat
   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } rme_mat_type;

   // classified item held between front and back
   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
      logic        [15:0] cos_pitch;
      logic               locked;
   } rme_item_type;

   // atan(2^-i) in 1/32768 degree
   function automatic logic signed [RME_ZW-1:0] rme_atan(input int idx);
      logic signed [RME_ZW-1:0] tab [0:RME_TABLE_LEN-1];
      tab = '{26'sd1474560, 26'sd870484, 26'sd459940, 26'sd233473, 26'sd117189,
              26'sd58652, 26'sd29333, 26'sd14667, 26'sd7334, 26'sd3667,
              26'sd1833, 26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57,
              26'sd29, 26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0, 26'sd0};
      return tab[idx];
   endfunction

endpackage

@@ hw/rtl/rme_front.sv @@
module rme_front import rme_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rme_mat_type        in_mat,
   input  logic [14:0]        lock_threshold,
   input  logic               q_full,
   output logic               q_push,
   output rme_item_type       q_data
);

   localparam int SQ = RME_SQRT_STEPS;

   logic              vld_ff  [0:SQ];
   rme_mat_type       mat_ff  [0:SQ];
   logic [30:0]       sq_ff;
   logic [30:0]       rem_ff  [1:SQ];
   logic [31:0]       res_ff  [1:SQ];
   logic [30:0]       rem_in  [1:SQ];
   logic [31:0]       res_in  [1:SQ];
   logic              en;
   logic signed [31:0] prod;
   logic [30:0]       d0;

   assign en       = !q_full;
   assign in_ready = en;
   assign prod     = in_mat.m21 * in_mat.m21;

   // 2^30 - m21^2, floored at zero
   assign d0 = (sq_ff >= 31'h4000_0000) ? '0 : 31'h4000_0000 - sq_ff;

   // one root bit per stage
   for (genvar k = 1; k <= SQ; k++) begin : g_step
      localparam logic [31:0] BIT = 32'(1) << (2 * (SQ - k));
      logic [30:0] rem_prev;
      logic [31:0] res_prev;
      logic [32:0] trial;
      if (k == 1) begin : g_first
         assign rem_prev = d0;
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign res_prev = res_ff[k-1];
      end
      assign trial = {1'b0, res_prev} + {1'b0, BIT};
      always_comb begin
         if ({2'b00, rem_prev} >= trial) begin
            rem_in[k] = rem_prev - trial[30:0];
            res_in[k] = (res_prev >> 1) + BIT;
         end else begin
            rem_in[k] = rem_prev;
            res_in[k] = res_prev >> 1;
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SQ; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= SQ; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         mat_ff[0] <= in_mat;
         sq_ff     <= prod[30:0];
         for (int k = 1; k <= SQ; k++) begin
            mat_ff[k] <= mat_ff[k-1];
            rem_ff[k] <= rem_in[k];
            res_ff[k] <= res_in[k];
         end
      end
   end

   // classify and hand over
   assign q_push           = vld_ff[SQ] && en;
   assign q_data.m00       = mat_ff[SQ].m00;
   assign q_data.m01       = mat_ff[SQ].m01;
   assign q_data.m10       = mat_ff[SQ].m10;
   assign q_data.m11       = mat_ff[SQ].m11;
   assign q_data.m20       = mat_ff[SQ].m20;
   assign q_data.m21       = mat_ff[SQ].m21;
   assign q_data.m22       = mat_ff[SQ].m22;
   assign q_data.cos_pitch = res_ff[SQ][15:0];
   assign q_data.locked    = res_ff[SQ][15:0] <= {1'b0, lock_threshold};

endmodule

@@ hw/rtl/rme_queue.sv @@
module rme_queue import rme_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rme_item_type push_data,
   input  logic         pop,
   output rme_item_type pop_data,
   output logic         full,
   output logic         empty
);

   localparam int AW = $clog2(RME_QUEUE_DEPTH);

   rme_item_type mem_ff [0:RME_QUEUE_DEPTH-1];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   cnt_ff;

   assign full     = cnt_ff == (AW+1)'(RME_QUEUE_DEPTH);
   assign empty    = cnt_ff == '0;
   assign pop_data = mem_ff[rd_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

@@ hw/rtl/rme_cordic.sv @@
module rme_cordic import rme_pkg::*; #(
   parameter int                 STAGES = RME_CORDIC_STAGES,
   parameter logic signed [15:0] LIMIT  = RME_ANGLE_MAX
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [16:0] y_in,
   input  logic signed [16:0] x_in,
   output logic signed [15:0] angle
);

   logic signed [RME_VW-1:0] x_ff [0:STAGES];
   logic signed [RME_VW-1:0] y_ff [0:STAGES];
   logic signed [RME_ZW-1:0] z_ff [0:STAGES];
   logic                     zero_ff [0:STAGES];
   logic signed [15:0]       angle_ff;

   logic signed [17:0]       xs, ys;
   logic signed [RME_ZW-1:0] z0;
   logic signed [RME_ZW-1:0] zr;
   logic signed [RME_ZW-9:0] rq;
   logic signed [15:0]       sat;

   // quadrant fold for negative x
   always_comb begin
      xs = 18'(x_in);
      ys = 18'(y_in);
      z0 = '0;
      if (x_in < 0) begin
         xs = -18'(x_in);
         ys = -18'(y_in);
         z0 = (y_in >= 0) ? RME_HALF_TURN : -RME_HALF_TURN;
      end
   end

   // rounding to 1/128 degree and clamp
   assign zr = z_ff[STAGES] + RME_ZW'(128);
   assign rq = zr[RME_ZW-1:8];
   always_comb begin
      if (rq > RME_ZW'(LIMIT))       sat = LIMIT;
      else if (rq < -RME_ZW'(LIMIT)) sat = -LIMIT;
      else                           sat = rq[15:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= RME_VW'(xs) <<< 14;
         y_ff[0]    <= RME_VW'(ys) <<< 14;
         z_ff[0]    <= z0;
         zero_ff[0] <= (x_in == 0) && (y_in == 0);
         // vectoring micro-rotations
         for (int i = 0; i < STAGES; i++) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + rme_atan(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - rme_atan(i);
            end
         end
         angle_ff <= zero_ff[STAGES] ? '0 : sat;
      end
   end

   assign angle = angle_ff;

endmodule

@@ hw/rtl/rme_back.sv @@
module rme_back import rme_pkg::*; #(
   parameter int STAGES = RME_CORDIC_STAGES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  rme_item_type       q_data,
   output logic               q_pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [14:0] pitch_angle,
   output logic signed [15:0] yaw_angle,
   output logic signed [15:0] roll_angle,
   output logic               gimbal_locked
);

   localparam int LAT = STAGES + 2;

   logic               vld_ff  [0:LAT-1];
   logic               lock_ff [0:LAT-1];
   logic               en;
   logic signed [16:0] py, px, yy, yx, ry, rx;
   logic signed [15:0] pitch_full;

   assign en    = !vld_ff[LAT-1] || out_ready;
   assign q_pop = !q_empty && en;

   // operand selection by branch
   always_comb begin
      py = -17'(q_data.m21);
      px = 17'({1'b0, q_data.cos_pitch});
      if (q_data.locked) begin
         yy = '0;
         yx = '0;
         ry = -17'(q_data.m10);
         rx = 17'(q_data.m00);
      end else begin
         yy = 17'(q_data.m20);
         yx = 17'(q_data.m22);
         ry = 17'(q_data.m01);
         rx = 17'(q_data.m11);
      end
   end

   rme_cordic #(.STAGES(STAGES), .LIMIT(RME_PITCH_MAX)) u_pitch (
      .clock(clock), .en(en), .y_in(py), .x_in(px), .angle(pitch_full));
   rme_cordic #(.STAGES(STAGES), .LIMIT(RME_ANGLE_MAX)) u_yaw (
      .clock(clock), .en(en), .y_in(yy), .x_in(yx), .angle(yaw_angle));
   rme_cordic #(.STAGES(STAGES), .LIMIT(RME_ANGLE_MAX)) u_roll (
      .clock(clock), .en(en), .y_in(ry), .x_in(rx), .angle(roll_angle));

   // valid and lock flag alongside the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= q_pop;
         for (int k = 1; k < LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lock_ff[0] <= q_data.locked;
         for (int k = 1; k < LAT; k++) lock_ff[k] <= lock_ff[k-1];
      end
   end

   assign out_valid     = vld_ff[LAT-1];
   assign gimbal_locked = lock_ff[LAT-1];
   assign pitch_angle   = pitch_full[14:0];

endmodule

@@ hw/rtl/rotation_matrix_to_euler.sv @@
// Path: an accepted request beat passes the m21 square register and the root
// pipeline, then the queue, then the input register, the CORDIC micro-rotation
// stages and the output register of the angle pipelines; rsp_tready stalls hold it up.
// Throughput: one matrix per cycle while rsp_tready is high; the stages square m21,
// take the square-root steps, the CORDIC micro-rotations and the round and clamp.
// Reset: synchronous, active high; clears valid bits, queue and lock_threshold.
module rotation_matrix_to_euler import rme_pkg::*; #(
   parameter int CORDIC_STAGES = RME_CORDIC_STAGES
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [111:0]  req_tdata,   // m00, m01, m10, m11, m20, m21, m22
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [47:0]   rsp_tdata,   // pitch_angle, yaw_angle, roll_angle, zero pad
   output logic          rsp_tuser,   // gimbal_locked
   input  logic          csr_wr_en,
   input  logic [14:0]   csr_wr_data  // lock_threshold
);

   logic [14:0]        thr_ff;
   rme_mat_type        mat;
   rme_item_type       push_data, pop_data;
   logic               push, pop, full, empty;
   logic signed [14:0] pitch;
   logic signed [15:0] yaw, roll;

   always_ff @(posedge clock) begin
      if (reset)          thr_ff <= '0;
      else if (csr_wr_en) thr_ff <= csr_wr_data;
   end

   assign mat.m00 = req_tdata[15:0];
   assign mat.m01 = req_tdata[31:16];
   assign mat.m10 = req_tdata[47:32];
   assign mat.m11 = req_tdata[63:48];
   assign mat.m20 = req_tdata[79:64];
   assign mat.m21 = req_tdata[95:80];
   assign mat.m22 = req_tdata[111:96];

   rme_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_mat(mat), .lock_threshold(thr_ff), .q_full(full), .q_push(push),
      .q_data(push_data));

   rme_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .pop(pop), .pop_data(pop_data), .full(full), .empty(empty));

   rme_back #(.STAGES(CORDIC_STAGES)) u_back (
      .clock(clock), .reset(reset), .q_empty(empty), .q_data(pop_data),
      .q_pop(pop), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .pitch_angle(pitch), .yaw_angle(yaw), .roll_angle(roll),
      .gimbal_locked(rsp_tuser));

   assign rsp_tdata = {1'b0, roll, yaw, pitch};

endmodule

@@ hw/rtl/rme_checker.sv @@
`include "rotation_matrix_to_euler_defines.svh"
module rme_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled result beat stays up
   `RME_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // no result right after reset
   `RME_ASSERT_RAW(a_rsp_reset, $past(reset), !rsp_tvalid)
   // locked beats carry zero yaw
   `RME_ASSERT_NOW(a_lock_yaw, rsp_tvalid && rsp_tuser, rsp_tdata[30:15] == 16'd0)
   // pitch within a quarter turn
   `RME_ASSERT_NOW(a_pitch_rng, rsp_tvalid, ($signed(rsp_tdata[14:0]) <= 15'sd11520) && ($signed(rsp_tdata[14:0]) >= -15'sd11520))

endmodule

bind rotation_matrix_to_euler rme_checker u_rme_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser));
